### hdl/h264ab_pkg.sv
// ----------------------------------------------------------------------------
// h264ab_pkg
// Shared types and constants for the RTP payload to Annex B converter.
// ----------------------------------------------------------------------------
package h264ab_pkg;

    // result kinds on the output tuser
    localparam logic [1:0] RES_DATA = 2'd0;
    localparam logic [1:0] RES_OK   = 2'd1;
    localparam logic [1:0] RES_ERR  = 2'd2;

    // default depth of the command queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // one command from the front: what the back must emit for one input byte
    typedef struct packed {
        logic       pfx;       // emit 00 00 00 01
        logic       dat;       // emit data_val
        logic [7:0] data_val;
        logic       sts;       // emit frame status
        logic       bad;       // status is error
    } t_cmd;

endpackage

### hdl/h264ab_front.sv
// ----------------------------------------------------------------------------
// h264ab_front
// Accepts payload bytes, tracks the RFC 6184 payload state and turns each
// byte into at most one emit command for the back end.
// ----------------------------------------------------------------------------
module h264ab_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tvalid,
    output logic                o_tready,
    input  logic [7:0]          i_tdata,   // data_byte
    input  logic [1:0]          i_tuser,   // payload_first, payload_final
    input  logic                i_tlast,   // frame_final
    input  logic                i_q_ready,
    output logic                o_q_push,
    output h264ab_pkg::t_cmd    o_q_cmd
);
    import h264ab_pkg::*;

    localparam logic [1:0] PK_IDLE   = 2'd0;
    localparam logic [1:0] PK_SINGLE = 2'd1;
    localparam logic [1:0] PK_FUA    = 2'd2;
    localparam logic [1:0] PK_STAPA  = 2'd3;

    localparam logic [4:0] NAL_FUA   = 5'd28;
    localparam logic [4:0] NAL_STAPA = 5'd24;

    logic [1:0]  r_kind,  n_kind;
    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_left,  n_left;
    logic [7:0]  r_hi,    n_hi;
    logic [2:0]  r_fnri,  n_fnri;
    logic        r_bad,   n_bad;

    t_cmd        w_cmd;
    logic        w_accept;
    logic        w_first;
    logic        w_last;
    logic        w_err;
    logic [15:0] w_dec;

    assign o_tready = i_q_ready;
    assign w_accept = i_tvalid & i_q_ready;
    assign w_first  = i_tuser[0];
    assign w_last   = i_tuser[1] | i_tlast;
    assign w_dec    = r_left - 16'd1;

    always_comb begin
        n_kind  = r_kind;
        n_phase = r_phase;
        n_left  = r_left;
        n_hi    = r_hi;
        n_fnri  = r_fnri;
        n_bad   = r_bad;
        w_err   = 1'b0;
        w_cmd   = '0;
        w_cmd.data_val = i_tdata;
        if (!r_bad) begin
            if (w_first && r_kind != PK_IDLE) begin
                w_err = 1'b1;
            end else if (!w_first && r_kind == PK_IDLE) begin
                w_err = 1'b1;
            end else if (w_first) begin
                if (i_tdata[4:0] == NAL_FUA) begin
                    n_kind  = PK_FUA;
                    n_fnri  = i_tdata[7:5];
                    n_phase = 2'd1;
                    w_err   = w_last;
                end else if (i_tdata[4:0] == NAL_STAPA) begin
                    n_kind  = PK_STAPA;
                    n_phase = 2'd0;
                    w_err   = w_last;
                end else begin
                    n_kind    = PK_SINGLE;
                    w_cmd.pfx = 1'b1;
                    w_cmd.dat = 1'b1;
                end
            end else if (r_kind == PK_SINGLE) begin
                w_cmd.dat = 1'b1;
            end else if (r_kind == PK_FUA) begin
                if (r_phase == 2'd1) begin
                    // start bit: rebuild the nal header from indicator and fu header
                    if (i_tdata[7]) begin
                        w_cmd.pfx      = 1'b1;
                        w_cmd.dat      = 1'b1;
                        w_cmd.data_val = {r_fnri, i_tdata[4:0]};
                    end
                    n_phase = 2'd2;
                end else begin
                    w_cmd.dat = 1'b1;
                end
            end else begin
                case (r_phase)
                    2'd0: begin
                        n_hi    = i_tdata;
                        n_phase = 2'd1;
                        w_err   = w_last;
                    end
                    2'd1: begin
                        n_left    = {r_hi, i_tdata};
                        w_cmd.pfx = 1'b1;
                        n_phase   = (n_left != 16'd0) ? 2'd2 : 2'd0;
                        w_err     = w_last && (n_left != 16'd0);
                    end
                    default: begin
                        w_cmd.dat = 1'b1;
                        n_left    = w_dec;
                        if (w_dec == 16'd0) begin
                            n_phase = 2'd0;
                        end else begin
                            w_err = w_last;
                        end
                    end
                endcase
            end
            if (w_err) begin
                n_bad = 1'b1;
            end
            if (w_err || w_last) begin
                n_kind  = PK_IDLE;
                n_phase = 2'd0;
                n_left  = 16'd0;
                n_hi    = 8'd0;
            end
        end
        if (i_tlast) begin
            w_cmd.sts = 1'b1;
            w_cmd.bad = n_bad;
            n_kind  = PK_IDLE;
            n_phase = 2'd0;
            n_left  = 16'd0;
            n_hi    = 8'd0;
            n_fnri  = 3'd0;
            n_bad   = 1'b0;
        end
    end

    assign o_q_cmd  = w_cmd;
    assign o_q_push = w_accept & (w_cmd.pfx | w_cmd.dat | w_cmd.sts);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= PK_IDLE;
            r_phase <= 2'd0;
            r_left  <= 16'd0;
            r_hi    <= 8'd0;
            r_fnri  <= 3'd0;
            r_bad   <= 1'b0;
        end else if (w_accept) begin
            r_kind  <= n_kind;
            r_phase <= n_phase;
            r_left  <= n_left;
            r_hi    <= n_hi;
            r_fnri  <= n_fnri;
            r_bad   <= n_bad;
        end
    end

endmodule

### hdl/h264ab_queue.sv
// ----------------------------------------------------------------------------
// h264ab_queue
// Small command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module h264ab_queue #(
    parameter int DEPTH = h264ab_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  h264ab_pkg::t_cmd    i_cmd,
    output logic                o_ready,
    input  logic                i_pop,
    output logic                o_valid,
    output h264ab_pkg::t_cmd    o_cmd
);
    import h264ab_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    t_cmd          r_head;
    logic          r_head_vld;
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] w_used;
    logic          w_push;
    logic          w_take;
    logic          w_mem_rd;
    logic          w_mem_wr;

    assign w_used   = r_cnt + CW'(r_head_vld);
    assign o_ready  = (w_used != CW'(DEPTH));
    assign o_valid  = r_head_vld;
    assign o_cmd    = r_head;
    assign w_push   = i_push & o_ready;
    // head register frees up when it is empty or popped
    assign w_take   = !r_head_vld || i_pop;
    assign w_mem_rd = w_take && (r_cnt != '0);
    // a push into an empty queue goes straight to the head register
    assign w_mem_wr = w_push && !(w_take && (r_cnt == '0));

    always_ff @(posedge i_clk) begin
        if (w_mem_wr) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_rd) begin
            r_head <= r_mem[r_rd];
        end else if (w_take && w_push) begin
            r_head <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_cnt      <= '0;
        end else begin
            if (w_take) begin
                r_head_vld <= w_mem_rd || w_push;
            end
            if (w_mem_wr) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_mem_rd) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_mem_wr && !w_mem_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_mem_rd && !w_mem_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### hdl/h264ab_back.sv
// ----------------------------------------------------------------------------
// h264ab_back
// Expands each command into start code, data byte and status transfers,
// one output transfer per cycle while the output is ready.
// ----------------------------------------------------------------------------
module h264ab_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  h264ab_pkg::t_cmd    i_q_cmd,
    output logic                o_q_pop,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic [7:0]          o_tdata,   // out_byte
    output logic [1:0]          o_tuser,   // result_kind
    output logic                o_tlast    // run_end
);
    import h264ab_pkg::*;

    localparam logic [2:0] PH_PFX0 = 3'd0;
    localparam logic [2:0] PH_PFX1 = 3'd1;
    localparam logic [2:0] PH_PFX2 = 3'd2;
    localparam logic [2:0] PH_PFX3 = 3'd3;
    localparam logic [2:0] PH_DAT  = 3'd4;
    localparam logic [2:0] PH_STS  = 3'd5;

    t_cmd       r_cmd;
    logic       r_busy;
    logic [2:0] r_ph, n_ph;
    logic       w_end;
    logic       w_load;
    logic [2:0] w_start;

    always_comb begin
        case (r_ph)
            PH_PFX3: w_end = !r_cmd.dat && !r_cmd.sts;
            PH_DAT:  w_end = !r_cmd.sts;
            PH_STS:  w_end = 1'b1;
            default: w_end = 1'b0;
        endcase
    end

    always_comb begin
        case (r_ph)
            PH_PFX0: n_ph = PH_PFX1;
            PH_PFX1: n_ph = PH_PFX2;
            PH_PFX2: n_ph = PH_PFX3;
            PH_PFX3: n_ph = r_cmd.dat ? PH_DAT : PH_STS;
            default: n_ph = PH_STS;
        endcase
    end

    // first phase of the command waiting at the queue head
    assign w_start = i_q_cmd.pfx ? PH_PFX0 : (i_q_cmd.dat ? PH_DAT : PH_STS);
    assign w_load  = !r_busy || (i_tready && w_end);
    assign o_q_pop = w_load & i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= PH_PFX0;
        end else if (w_load) begin
            r_busy <= i_q_valid;
            r_ph   <= w_start;
        end else if (i_tready) begin
            r_ph   <= n_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    always_comb begin
        case (r_ph)
            PH_PFX3: o_tdata = 8'h01;
            PH_DAT:  o_tdata = r_cmd.data_val;
            default: o_tdata = 8'h00;
        endcase
    end

    assign o_tvalid = r_busy;
    assign o_tuser  = (r_ph == PH_STS) ? (r_cmd.bad ? RES_ERR : RES_OK) : RES_DATA;
    assign o_tlast  = w_end;

endmodule

### hdl/h264_rtp_payload_to_annexb.sv
// ----------------------------------------------------------------------------
// h264_rtp_payload_to_annexb
// RFC 6184 RTP payload (single NAL, FU-A, STAP-A) to Annex B byte stream.
// ----------------------------------------------------------------------------
// path: a command passes the queue head and the back end command register
// throughput: one input byte per cycle while the output is ready and each
//   byte makes one result; a byte that opens a unit makes up to six results,
//   and the output port at one transfer per cycle while ready sets the pace
// reset: synchronous active low, clears payload state and empties the queue
// ----------------------------------------------------------------------------
module h264_rtp_payload_to_annexb #(
    parameter int QUEUE_DEPTH = h264ab_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // data_byte
    input  logic [1:0] i_s_axis_tuser,   // payload_first, payload_final
    input  logic       i_s_axis_tlast,   // frame_final
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // out_byte
    output logic [1:0] o_m_axis_tuser,   // result_kind
    output logic       o_m_axis_tlast    // run_end
);
    import h264ab_pkg::*;

    logic w_push;
    logic w_q_ready;
    logic w_q_valid;
    logic w_pop;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;

    h264ab_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (i_s_axis_tvalid),
        .o_tready  (o_s_axis_tready),
        .i_tdata   (i_s_axis_tdata),
        .i_tuser   (i_s_axis_tuser),
        .i_tlast   (i_s_axis_tlast),
        .i_q_ready (w_q_ready),
        .o_q_push  (w_push),
        .o_q_cmd   (w_push_cmd)
    );

    h264ab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_head_cmd)
    );

    h264ab_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_head_cmd),
        .o_q_pop   (w_pop),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tuser   (o_m_axis_tuser),
        .o_tlast   (o_m_axis_tlast)
    );

endmodule

### hdl/h264ab_chk.sv
// ----------------------------------------------------------------------------
// h264ab_chk
// Port-level checks for the RTP payload to Annex B converter.
// ----------------------------------------------------------------------------
module h264ab_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [1:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);
    import h264ab_pkg::*;

    // nothing offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // status transfers carry a zero byte and close their run
    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != RES_DATA)
        |-> (o_m_axis_tdata == 8'h00 && o_m_axis_tlast))
        else $error("malformed status transfer");

    // only the three defined kinds appear
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == RES_DATA || o_m_axis_tuser == RES_OK
                             || o_m_axis_tuser == RES_ERR))
        else $error("undefined result kind");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind h264_rtp_payload_to_annexb h264ab_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

### verif/tb_h264_rtp_payload_to_annexb.sv
// ----------------------------------------------------------------------------
// tb_h264_rtp_payload_to_annexb
// Self-checking bench for the RTP payload to Annex B converter. A queue-fed
// driver sends payload bytes, a bit-accurate predictor of the depacketizer
// builds the expected Annex B stream, and a monitor checks every output
// transfer against it. Both stream sides stall at random except in a calm phase.
// ----------------------------------------------------------------------------
module tb_h264_rtp_payload_to_annexb;
    import h264ab_pkg::*;

    localparam logic [4:0] NAL_STAPA = 5'd24;
    localparam logic [4:0] NAL_FUA   = 5'd28;
    localparam int         IDLE_PCT  = 21;

    typedef enum logic [1:0] {PK_IDLE, PK_SINGLE, PK_FUA, PK_STAPA} t_pkind;

    typedef struct {
        logic [7:0] data;
        logic       pl_start;
        logic       pl_end;
        logic       fr_end;
    } t_rtp_byte;

    typedef struct {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } t_annexb_out;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data = '0;
    logic [1:0] s_user = '0;
    logic       s_last = 1'b0;
    logic       m_ready = 1'b0;
    logic       calm = 1'b0;
    wire        o_s_axis_tready;
    wire        o_m_axis_tvalid;
    wire  [7:0] o_m_axis_tdata;
    wire  [1:0] o_m_axis_tuser;
    wire        o_m_axis_tlast;

    h264_rtp_payload_to_annexb dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),    // data_byte
        .i_s_axis_tuser  (s_user),    // payload_first, payload_final
        .i_s_axis_tlast  (s_last),    // frame_final
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // out_byte
        .o_m_axis_tuser  (o_m_axis_tuser),  // result_kind
        .o_m_axis_tlast  (o_m_axis_tlast)   // run_end
    );

    always #10 i_clk = ~i_clk;

    t_rtp_byte   rtp_pending[$];
    t_rtp_byte   frame_buf[$];
    t_rtp_byte   cur_byte;
    t_annexb_out annexb_q[$];
    t_annexb_out step_res[$];
    int          n_queued = 0;
    int          n_accepted = 0;
    int          n_results = 0;
    int          n_ok_frames = 0;
    int          n_bad_frames = 0;
    int          n_errors = 0;

    // predictor state
    t_pkind      pk = PK_IDLE;
    logic [1:0]  hdr_phase = '0;
    logic [15:0] unit_left = '0;
    logic [7:0]  size_hi = '0;
    logic [2:0]  fu_fnri = '0;
    logic        frame_bad = 1'b0;

    task automatic put_byte(input logic [7:0] b, input logic [1:0] kind);
        step_res.push_back('{b, kind, 1'b0});
    endtask

    task automatic put_start_code();
        put_byte(8'h00, RES_DATA);
        put_byte(8'h00, RES_DATA);
        put_byte(8'h00, RES_DATA);
        put_byte(8'h01, RES_DATA);
    endtask

    task automatic drop_payload();
        pk        = PK_IDLE;
        hdr_phase = '0;
        unit_left = '0;
        size_hi   = '0;
    endtask

    task automatic flag_bad();
        frame_bad = 1'b1;
        drop_payload();
    endtask

    task automatic predict_annexb(input t_rtp_byte it);
        logic ends;
        ends = it.pl_end | it.fr_end;
        step_res.delete();
        if (!frame_bad) begin
            if (it.pl_start && pk != PK_IDLE) begin
                flag_bad();
            end else if (!it.pl_start && pk == PK_IDLE) begin
                flag_bad();
            end else if (it.pl_start) begin
                if (it.data[4:0] == NAL_FUA) begin
                    pk        = PK_FUA;
                    fu_fnri   = it.data[7:5];
                    hdr_phase = 2'd1;
                    if (ends) flag_bad();
                end else if (it.data[4:0] == NAL_STAPA) begin
                    pk        = PK_STAPA;
                    hdr_phase = 2'd0;
                    if (ends) flag_bad();
                end else begin
                    pk = PK_SINGLE;
                    put_start_code();
                    put_byte(it.data, RES_DATA);
                end
            end else if (pk == PK_SINGLE) begin
                put_byte(it.data, RES_DATA);
            end else if (pk == PK_FUA) begin
                if (hdr_phase == 2'd1) begin
                    // start bit: rebuild the nal header from indicator and fu header
                    if (it.data[7]) begin
                        put_start_code();
                        put_byte({fu_fnri, it.data[4:0]}, RES_DATA);
                    end
                    hdr_phase = 2'd2;
                end else begin
                    put_byte(it.data, RES_DATA);
                end
            end else begin
                if (hdr_phase == 2'd0) begin
                    size_hi   = it.data;
                    hdr_phase = 2'd1;
                    if (ends) flag_bad();
                end else if (hdr_phase == 2'd1) begin
                    unit_left = {size_hi, it.data};
                    put_start_code();
                    hdr_phase = (unit_left != 0) ? 2'd2 : 2'd0;
                    if (ends && unit_left != 0) flag_bad();
                end else begin
                    put_byte(it.data, RES_DATA);
                    unit_left = unit_left - 16'd1;
                    if (unit_left == 0) begin
                        hdr_phase = 2'd0;
                    end else if (ends) begin
                        flag_bad();
                    end
                end
            end
            if (ends && !frame_bad) drop_payload();
        end
        if (it.fr_end) begin
            put_byte(8'h00, frame_bad ? RES_ERR : RES_OK);
            drop_payload();
            fu_fnri   = '0;
            frame_bad = 1'b0;
        end
        if (step_res.size() != 0) step_res[step_res.size() - 1].last = 1'b1;
        foreach (step_res[i]) annexb_q.push_back(step_res[i]);
    endtask

    // source side: one transfer per accepted payload byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                predict_annexb(cur_byte);
                n_accepted++;
            end
            if (!s_valid || o_s_axis_tready) begin
                if (rtp_pending.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_byte = rtp_pending.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= cur_byte.data;
                    s_user  <= {cur_byte.pl_end, cur_byte.pl_start};
                    s_last  <= cur_byte.fr_end;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // sink side: compare each output transfer with the oldest expected one
    always @(posedge i_clk) begin
        t_annexb_out want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            n_results++;
            if (o_m_axis_tuser == RES_OK) n_ok_frames++;
            if (o_m_axis_tuser == RES_ERR) n_bad_frames++;
            if (annexb_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected output data=%02h kind=%0d last=%0b", $time,
                         o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
            end else begin
                want = annexb_q.pop_front();
                if (o_m_axis_tdata !== want.data || o_m_axis_tuser !== want.kind ||
                    o_m_axis_tlast !== want.last) begin
                    n_errors++;
                    $display({"%0t: mismatch expected data=%02h kind=%0d last=%0b,",
                              " got data=%02h kind=%0d last=%0b"},
                             $time, want.data, want.kind, want.last,
                             o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic ps, input logic pe,
                             input logic fe);
        rtp_pending.push_back('{d, ps, pe, fe});
        n_queued++;
    endtask

    task automatic frame_add(input logic [7:0] d);
        frame_buf.push_back('{d, 1'b0, 1'b0, 1'b0});
    endtask

    // one payload with random content, well-formed unless a stap-a size runs past it
    task automatic add_payload();
        int         start_idx;
        int         len;
        int         units;
        int         sz;
        logic [7:0] hdr;
        start_idx = frame_buf.size();
        hdr = 8'($urandom);
        case ($urandom_range(0, 2))
            0: begin
                while (hdr[4:0] == NAL_FUA || hdr[4:0] == NAL_STAPA) begin
                    hdr[4:0] = 5'($urandom);
                end
                frame_add(hdr);
                len = $urandom_range(0, 5);
                repeat (len) frame_add(8'($urandom));
            end
            1: begin
                hdr[4:0] = NAL_FUA;
                frame_add(hdr);
                frame_add(8'($urandom));
                len = $urandom_range(0, 4);
                repeat (len) frame_add(8'($urandom));
            end
            default: begin
                hdr[4:0] = NAL_STAPA;
                frame_add(hdr);
                units = $urandom_range(1, 2);
                for (int u = 0; u < units; u++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        // huge size: payload ends inside the unit
                        frame_add(8'($urandom_range(1, 255)));
                        frame_add(8'($urandom));
                        len = $urandom_range(0, 3);
                        repeat (len) frame_add(8'($urandom));
                        break;
                    end
                    sz = $urandom_range(0, 4);
                    frame_add(8'h00);
                    frame_add(8'(sz));
                    repeat (sz) frame_add(8'($urandom));
                end
            end
        endcase
        frame_buf[start_idx].pl_start = 1'b1;
        frame_buf[frame_buf.size() - 1].pl_end = 1'b1;
    endtask

    task automatic add_frame(input int mode);
        int idx;
        int npl;
        frame_buf.delete();
        if (mode == 0) begin
            // noise: random bytes and marks
            npl = $urandom_range(1, 4);
            repeat (npl) frame_buf.push_back('{8'($urandom), 1'($urandom), 1'($urandom), 1'b0});
        end else begin
            npl = $urandom_range(1, 3);
            repeat (npl) add_payload();
            if (mode == 1) begin
                idx = $urandom_range(0, frame_buf.size() - 1);
                case ($urandom_range(0, 2))
                    0: frame_buf[idx].pl_start = ~frame_buf[idx].pl_start;
                    1: frame_buf[idx].pl_end = ~frame_buf[idx].pl_end;
                    default: if (frame_buf.size() > 1) void'(frame_buf.pop_back());
                endcase
            end
            // the frame end also closes the payload, so its own end mark is optional
            if ($urandom_range(0, 3) == 0) frame_buf[frame_buf.size() - 1].pl_end = 1'b0;
        end
        frame_buf[frame_buf.size() - 1].fr_end = 1'b1;
        foreach (frame_buf[i]) send_byte(frame_buf[i].data, frame_buf[i].pl_start,
                                         frame_buf[i].pl_end, frame_buf[i].fr_end);
    endtask

    task automatic add_random(input int upto);
        int r;
        while (n_queued < upto) begin
            r = $urandom_range(0, 99);
            add_frame(r < 10 ? 0 : (r < 25 ? 1 : 2));
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (n_accepted != n_queued || annexb_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int n_directed;
        // single nal unit with extreme byte values
        send_byte(8'h65, 1'b1, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1, 1'b1);
        // fu-a of one byte is too short
        send_byte(8'h7C, 1'b1, 1'b1, 1'b1);
        // fu-a start with end and reserved bits set, they are ignored
        send_byte(8'h5C, 1'b1, 1'b0, 1'b0);
        send_byte(8'hE5, 1'b0, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b1, 1'b1);
        // fu-a without start bit, forbidden bit set
        send_byte(8'hFC, 1'b1, 1'b0, 1'b0);
        send_byte(8'h05, 1'b0, 1'b1, 1'b1);
        // stap-a of two bytes: short, size cut off
        send_byte(8'h18, 1'b1, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1, 1'b1);
        // stap-a with a zero size unit and a one byte unit, then a single nal
        send_byte(8'h78, 1'b1, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0, 1'b0);
        send_byte(8'h67, 1'b0, 1'b1, 1'b0);
        send_byte(8'h41, 1'b1, 1'b0, 1'b0);
        send_byte(8'h9A, 1'b0, 1'b1, 1'b1);
        // byte with no open payload
        send_byte(8'h22, 1'b0, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0, 1'b1);
        // new payload while one is open
        send_byte(8'h41, 1'b1, 1'b0, 1'b0);
        send_byte(8'h41, 1'b1, 1'b0, 1'b1);
        // stap-a unit longer than its payload
        send_byte(8'h18, 1'b1, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'h03, 1'b0, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1, 1'b1);
        n_directed = n_queued;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();
        add_random(n_directed + 60);
        wait_drained();
        calm <= 1'b1;
        add_random(n_directed + 110);
        wait_drained();
        calm <= 1'b0;
        add_random(n_directed + 170);
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("sent %0d payload bytes (%0d directed), checked %0d output transfers",
                 n_accepted, n_directed, n_results);
        $display("frames closed: %0d ok, %0d with error status", n_ok_frames, n_bad_frames);
        if (n_errors == 0 && annexb_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout: %0d of %0d bytes accepted, %0d results pending",
                 n_accepted, n_queued, annexb_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
